// ===== rtl/u8dw_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types, constants and the display width lookup for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int CP_BITS = 21;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int N_ZERO  = 16;
  localparam int N_WIDE  = 14;
  localparam int PEND_N  = 4;

  typedef logic [CP_BITS-1:0] cp_t;

  typedef struct packed {
    cp_t  cp;
    logic run_last;
    logic text_done;
  } q_entry_t;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;
  localparam logic [7:0] CONT_DATA  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD2_DATA = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD3_DATA = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD4_DATA = 8'h07;

  localparam cp_t CTRL_END  = 21'h00020;
  localparam cp_t DEL_START = 21'h0007F;
  localparam cp_t C1_END    = 21'h000A0;

  localparam cp_t ZERO_LO [N_ZERO] = '{
    21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064B, 21'h00670,
    21'h006D6, 21'h00E31, 21'h00E34, 21'h01AB0, 21'h01DC0, 21'h0200B,
    21'h020D0, 21'h0FE00, 21'h0FE20, 21'h1F3FB};
  localparam cp_t ZERO_HI [N_ZERO] = '{
    21'h0036F, 21'h00489, 21'h005BD, 21'h0061A, 21'h0065F, 21'h00670,
    21'h006DC, 21'h00E31, 21'h00E3A, 21'h01AFF, 21'h01DFF, 21'h0200F,
    21'h020F0, 21'h0FE0F, 21'h0FE2F, 21'h1F3FF};
  localparam cp_t WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000,
    21'h0AC00, 21'h0F900, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F300,
    21'h1F900, 21'h20000};
  localparam cp_t WIDE_HI [N_WIDE] = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
    21'h0D7A3, 21'h0FAFF, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F64F,
    21'h1F9FF, 21'h3FFFD};

  function automatic logic [1:0] cell_width(input cp_t cp);
    logic zero_hit;
    logic wide_hit;
    logic [1:0] w;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) zero_hit = 1'b1;
    end
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) wide_hit = 1'b1;
    end
    if (cp == '0) begin
      w = 2'd1;
    end else if (cp < CTRL_END || (cp >= DEL_START && cp < C1_END)) begin
      w = 2'd0;
    end else if (zero_hit) begin
      w = 2'd0;
    end else if (wide_hit) begin
      w = 2'd2;
    end else begin
      w = 2'd1;
    end
    return w;
  endfunction

endpackage

// ===== rtl/u8dw_front.sv =====
// ----------------------------------------------------------------------------
// u8dw_front
// Accepts text bytes, tracks the open UTF-8 sequence and hands the code points
// that each byte yields, one per cycle while the queue is not full, to the queue.
// ----------------------------------------------------------------------------
module u8dw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               q_push,
  output u8dw_pkg::q_entry_t q_din
);
  import u8dw_pkg::*;

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] held_r [2];
  logic [1:0] exp_r, exp_nxt;
  logic [1:0] seen_r, seen_nxt;
  cp_t        part_r, part_nxt;
  logic       held_we;

  cp_t        pcp_r [PEND_N];
  logic [2:0] pcnt_r;
  logic       plast_r;

  cp_t        lst [PEND_N];
  logic [2:0] n;
  logic       accept;
  logic       is_cont, is_l2, is_l3, is_l4, is_lead, seq_open, done_seq;
  logic [1:0] seen_inc;
  cp_t        part_shift;
  cp_t        byte_cp;

  assign is_cont    = (in_byte & CONT_MASK) == CONT_VAL;
  assign is_l2      = (in_byte & LEAD2_MASK) == LEAD2_VAL;
  assign is_l3      = (in_byte & LEAD3_MASK) == LEAD3_VAL;
  assign is_l4      = (in_byte & LEAD4_MASK) == LEAD4_VAL;
  assign is_lead    = is_l2 || is_l3 || is_l4;
  assign seq_open   = exp_r != 2'd0;
  assign seen_inc   = seen_r + 2'd1;
  assign done_seq   = seq_open && is_cont && (seen_inc >= exp_r);
  assign part_shift = {part_r[CP_BITS-7:0], in_byte[5:0]};
  assign byte_cp    = cp_t'(in_byte);

  assign q_push    = (pcnt_r != 3'd0) && !q_full;
  assign in_tready = (pcnt_r == 3'd0) || (pcnt_r == 3'd1 && q_push);
  assign accept    = in_tvalid && in_tready;

  assign q_din.cp        = pcp_r[0];
  assign q_din.run_last  = pcnt_r == 3'd1;
  assign q_din.text_done = (pcnt_r == 3'd1) && plast_r;

  always_comb begin
    for (int i = 0; i < PEND_N; i++) lst[i] = '0;
    n = 3'd0;
    if (seq_open && is_cont) begin
      if (done_seq) begin
        lst[n[1:0]] = part_shift;
        n = n + 3'd1;
      end else if (in_last) begin
        lst[n[1:0]] = cp_t'(lead_r);
        n = n + 3'd1;
        if (seen_r == 2'd1) begin
          lst[n[1:0]] = cp_t'(held_r[0]);
          n = n + 3'd1;
        end
        lst[n[1:0]] = byte_cp;
        n = n + 3'd1;
      end
    end else begin
      if (seq_open) begin
        lst[n[1:0]] = cp_t'(lead_r);
        n = n + 3'd1;
        if (seen_r >= 2'd1) begin
          lst[n[1:0]] = cp_t'(held_r[0]);
          n = n + 3'd1;
        end
        if (seen_r >= 2'd2) begin
          lst[n[1:0]] = cp_t'(held_r[1]);
          n = n + 3'd1;
        end
      end
      if (!is_lead || in_last) begin
        lst[n[1:0]] = byte_cp;
        n = n + 3'd1;
      end
    end
  end

  always_comb begin
    lead_nxt = lead_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    part_nxt = part_r;
    held_we  = 1'b0;
    if (seq_open && is_cont) begin
      part_nxt = part_shift;
      seen_nxt = seen_inc;
      if (done_seq) begin
        exp_nxt  = 2'd0;
        seen_nxt = 2'd0;
      end else begin
        held_we = 1'b1;
      end
    end else if (is_lead) begin
      lead_nxt = in_byte;
      seen_nxt = 2'd0;
      if (is_l2) begin
        exp_nxt  = 2'd1;
        part_nxt = cp_t'(in_byte & LEAD2_DATA);
      end else if (is_l3) begin
        exp_nxt  = 2'd2;
        part_nxt = cp_t'(in_byte & LEAD3_DATA);
      end else begin
        exp_nxt  = 2'd3;
        part_nxt = cp_t'(in_byte & LEAD4_DATA);
      end
    end else begin
      exp_nxt  = 2'd0;
      seen_nxt = 2'd0;
    end
    if (in_last) begin
      exp_nxt  = 2'd0;
      seen_nxt = 2'd0;
      lead_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 8'd0;
      exp_r   <= 2'd0;
      seen_r  <= 2'd0;
      part_r  <= '0;
      pcnt_r  <= 3'd0;
      plast_r <= 1'b0;
    end else begin
      if (accept) begin
        lead_r  <= lead_nxt;
        exp_r   <= exp_nxt;
        seen_r  <= seen_nxt;
        part_r  <= part_nxt;
        pcnt_r  <= n;
        plast_r <= in_last;
      end else if (q_push) begin
        pcnt_r <= pcnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[seen_r[0]] <= in_byte & CONT_DATA | (in_byte & ~CONT_DATA);
    end
    if (accept) begin
      for (int i = 0; i < PEND_N; i++) pcp_r[i] <= lst[i];
    end else if (q_push) begin
      for (int i = 0; i < PEND_N - 1; i++) pcp_r[i] <= pcp_r[i+1];
    end
  end

endmodule

// ===== rtl/u8dw_fifo.sv =====
// ----------------------------------------------------------------------------
// u8dw_fifo
// Short queue of decoded code points between the decoder and the width stage.
// ----------------------------------------------------------------------------
module u8dw_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8dw_pkg::q_entry_t din,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output u8dw_pkg::q_entry_t dout
);
  import u8dw_pkg::*;

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full  = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign valid = cnt_r != '0;
  assign dout  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= din;
  end

endmodule

// ===== rtl/u8dw_back.sv =====
// ----------------------------------------------------------------------------
// u8dw_back
// Looks up the display width of each code point, keeps the saturating
// running total and holds the result in the output register.
// ----------------------------------------------------------------------------
module u8dw_back #(
  parameter int TOTAL_WIDTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  u8dw_pkg::q_entry_t q_dout,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output u8dw_pkg::cp_t      out_cp,
  output logic [1:0]         out_width,
  output logic [15:0]        out_total,
  output logic               out_run_last,
  output logic               out_text_done
);
  import u8dw_pkg::*;

  localparam logic [TOTAL_WIDTH_BITS-1:0] CAP = {TOTAL_WIDTH_BITS{1'b1}};

  logic                        a_valid_r;
  q_entry_t                    a_ent_r;
  logic [1:0]                  a_w_r;
  logic                        o_valid_r;
  cp_t                         o_cp_r;
  logic [1:0]                  o_w_r;
  logic [15:0]                 o_tot_r;
  logic                        o_rl_r, o_td_r;
  logic [TOTAL_WIDTH_BITS-1:0] tot_r, tot_nxt;
  logic [TOTAL_WIDTH_BITS:0]   sum;
  logic                        o_adv, a_adv, a_move;

  assign o_adv  = !o_valid_r || out_tready;
  assign a_move = a_valid_r && o_adv;
  assign a_adv  = !a_valid_r || o_adv;
  assign q_pop  = q_valid && a_adv;

  assign sum     = {1'b0, tot_r} + (TOTAL_WIDTH_BITS+1)'(a_w_r);
  assign tot_nxt = sum[TOTAL_WIDTH_BITS] ? CAP : sum[TOTAL_WIDTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      tot_r     <= '0;
    end else begin
      if (a_adv) a_valid_r <= q_valid;
      if (o_adv) o_valid_r <= a_valid_r;
      if (a_move) tot_r <= a_ent_r.text_done ? '0 : tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_ent_r <= q_dout;
      a_w_r   <= cell_width(q_dout.cp);
    end
    if (a_move) begin
      o_cp_r  <= a_ent_r.cp;
      o_w_r   <= a_w_r;
      o_tot_r <= 16'(tot_nxt);
      o_rl_r  <= a_ent_r.run_last;
      o_td_r  <= a_ent_r.text_done;
    end
  end

  assign out_tvalid    = o_valid_r;
  assign out_cp        = o_cp_r;
  assign out_width     = o_w_r;
  assign out_total     = o_tot_r;
  assign out_run_last  = o_rl_r;
  assign out_text_done = o_td_r;

endmodule

// ===== rtl/utf8_decode_display_width.sv =====
// ----------------------------------------------------------------------------
// utf8_decode_display_width
// Lenient UTF-8 decoder that tags every code point with its terminal width
// and a saturating running width total per text.
//
// Channel  Dir  tdata                                   tlast     tuser
// in_      in   [7:0] text_byte                         text_last -
// out_     out  [20:0] code_point, [22:21] width,       run_last  [0] text_done
//               [38:23] width_total, [39] zero
//
// A byte yielding at most one code point is taken every cycle while the queue
// is not full. A byte that yields k code points holds in_tready low until the
// decoder hands the last of them, one per cycle while the queue is not full, to
// a four-entry queue. Each code point passes the pending register, the queue,
// the width lookup register and the output register before out_tvalid.
// Reset clears the decoder, queue, pipeline valids and the running total.
// A stall on out_tready backs up the queue before it reaches in_tready.
// ----------------------------------------------------------------------------
module utf8_decode_display_width #(
  parameter int TOTAL_WIDTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [20:0] code_point, [22:21] display_width,
                                  // [38:23] width_total, [39] zero
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] text_done
);
  import u8dw_pkg::*;

  q_entry_t    q_din, q_dout;
  logic        q_push, q_pop, q_full, q_valid;
  cp_t         o_cp;
  logic [1:0]  o_w;
  logic [15:0] o_tot;
  logic        o_rl, o_td;

  u8dw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  u8dw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  u8dw_back #(
    .TOTAL_WIDTH_BITS (TOTAL_WIDTH_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_dout        (q_dout),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_cp        (o_cp),
    .out_width     (o_w),
    .out_total     (o_tot),
    .out_run_last  (o_rl),
    .out_text_done (o_td)
  );

  assign out_tdata = {1'b0, o_tot, o_w, o_cp};
  assign out_tlast = o_rl;
  assign out_tuser = o_td;

`ifndef ASSERT_OFF
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("text_done without run_last");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:21] != 2'd3)
    else $error("display width out of range");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_din.text_done |-> q_din.run_last)
    else $error("queued text_done without run_last");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");
`endif

endmodule
